@@ rtl/brapq_pkg.sv @@
// ----------------------------------------------------------------------------
// brapq_pkg
// Shared constants and types for the blocked range-add / point-query store.
// ----------------------------------------------------------------------------
package brapq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_BLOCKS   = 64;

  localparam int POS_W   = 11;                     // position field width
  localparam int IDX_W   = 10;                     // position - 1, block index
  localparam int BS_W    = 6;                      // block size register width
  localparam int VAL_W   = 64;
  localparam int ELEM_AW = $clog2(MAX_ELEMENTS);
  localparam int BLK_AW  = $clog2(MAX_BLOCKS);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [0:0] REG_ELEMENT_COUNT = 1'd0;
  localparam logic [0:0] REG_BLOCK_SIZE    = 1'd1;

  localparam logic [2:0] REQ_NONE     = 3'd0;
  localparam logic [2:0] REQ_ELEM_ADD = 3'd1;
  localparam logic [2:0] REQ_TAG_ADD  = 3'd2;
  localparam logic [2:0] REQ_LOAD     = 3'd3;
  localparam logic [2:0] REQ_QUERY    = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ELEM_AW-1:0] elem_addr;
    logic [BLK_AW-1:0]  tag_addr;
    logic               use_tag;
    logic [VAL_W-1:0]   value;
  } brapq_req_t;

endpackage

@@ rtl/brapq_div.sv @@
// ----------------------------------------------------------------------------
// brapq_div
// Restoring divider, one quotient bit per cycle: position index by block size.
// ----------------------------------------------------------------------------
module brapq_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [brapq_pkg::IDX_W-1:0] dividend,
  input  logic [brapq_pkg::BS_W-1:0]  divisor,
  output logic                      done,
  output logic [brapq_pkg::IDX_W-1:0] quo,
  output logic [brapq_pkg::BS_W-1:0]  rem
);
  import brapq_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0] quo_r, quo_nxt;
  logic [BS_W-1:0]  rem_r, rem_nxt;
  logic [BS_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BS_W:0]    shifted;
  logic [BS_W+1:0]  trial;

  assign shifted = {rem_r, quo_r[IDX_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(IDX_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[IDX_W-2:0], ~trial[BS_W+1]};
      rem_nxt = trial[BS_W+1] ? shifted[BS_W-1:0] : trial[BS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/brapq_store.sv @@
// ----------------------------------------------------------------------------
// brapq_store
// Element and tag memories with a registered read followed by an add and write-back.
// ----------------------------------------------------------------------------
module brapq_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brapq_pkg::brapq_req_t         req,
  output logic                          resp_valid,
  output logic [brapq_pkg::VAL_W-1:0]   resp_data
);
  import brapq_pkg::*;

  logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] tag_mem  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tag_vld_r;

  logic [VAL_W-1:0] elem_rd_r;
  logic [VAL_W-1:0] tag_rd_r;
  logic             tag_hit_r;
  logic [2:0]       s1_kind_r;
  logic [ELEM_AW-1:0] s1_elem_addr_r;
  logic [BLK_AW-1:0]  s1_tag_addr_r;
  logic             s1_use_tag_r;
  logic [VAL_W-1:0] s1_value_r;
  logic [VAL_W-1:0] tag_eff;

  // never-written tags read as zero
  assign tag_eff = (s1_use_tag_r && tag_hit_r) ? tag_rd_r : '0;

  always_ff @(posedge clk) begin
    elem_rd_r <= elem_mem[req.elem_addr];
    if (req.kind == REQ_LOAD) begin
      elem_mem[req.elem_addr] <= req.value;
    end else if (s1_kind_r == REQ_ELEM_ADD) begin
      elem_mem[s1_elem_addr_r] <= elem_rd_r + s1_value_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[req.tag_addr];
    if (s1_kind_r == REQ_TAG_ADD) begin
      tag_mem[s1_tag_addr_r] <= tag_eff + s1_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= '0;
      s1_kind_r <= REQ_NONE;
    end else begin
      if (s1_kind_r == REQ_TAG_ADD) begin
        tag_vld_r[s1_tag_addr_r] <= 1'b1;
      end
      s1_kind_r <= req.kind;
    end
    tag_hit_r      <= tag_vld_r[req.tag_addr];
    s1_elem_addr_r <= req.elem_addr;
    s1_tag_addr_r  <= req.tag_addr;
    s1_use_tag_r   <= req.use_tag;
    s1_value_r     <= req.value;
  end

  assign resp_valid = (s1_kind_r == REQ_QUERY);
  assign resp_data  = elem_rd_r + tag_eff;

endmodule

@@ rtl/block_range_add_point_query.sv @@
// ----------------------------------------------------------------------------
// block_range_add_point_query
// Blocked range-add / point-query store with one lazy add tag per block, for the first 64 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_op, in_left, in_right, in_value) are taken on
//   in_valid && !in_stall; one item is worked at a time. A query gives one
//   out_result item on out_valid && !out_stall; loads and adds give none,
//   nor do items with bad positions or a reversed range.
//   Per item: a load writes its element; a query runs the block index
//   divide, one memory read and one add; an add runs two divides (left
//   and right block) and then walks one step per cycle, a step being one
//   edge element or one whole-block tag. With block_size near the square
//   root of the count that is roughly 2*block_size + count/block_size
//   steps; whole blocks past the tag array are walked element by element.
//   While a result waits on out_stall the block still takes new items; a
//   later query waits before its read until the output register is free.
//   Reset clears control state and the tag valid bits, so all tags read as
//   zero at once; no clearing pass. Element contents are undefined until
//   loaded. Configuration writes (cfg_we) must come only while idle.
// ----------------------------------------------------------------------------
module block_range_add_point_query (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [brapq_pkg::POS_W-1:0]   in_left,
  input  logic [brapq_pkg::POS_W-1:0]   in_right,
  input  logic signed [brapq_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [brapq_pkg::VAL_W-1:0] out_result,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [brapq_pkg::POS_W-1:0]   cfg_data
);
  import brapq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_L = 3'd1;
  localparam logic [2:0] S_DIV_R = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_QRY   = 3'd4;
  localparam logic [2:0] S_QWAIT = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  localparam logic [POS_W-1:0] CNT_MAX   = POS_W'(MAX_ELEMENTS);
  localparam logic [IDX_W-1:0] BLK_LIMIT = IDX_W'(MAX_BLOCKS);

  logic [POS_W-1:0] elem_count_r, elem_count_nxt;
  logic [BS_W-1:0]  blk_size_r, blk_size_nxt;
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [POS_W-1:0] left_r, left_nxt;
  logic [POS_W-1:0] right_r, right_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] blk_r, blk_nxt;
  logic [IDX_W-1:0] bl_r, bl_nxt;
  logic [IDX_W-1:0] br_r, br_nxt;
  logic [BS_W-1:0]  off_r, off_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_result_r, out_result_nxt;

  logic [POS_W-1:0] cnt_eff;
  logic [BS_W-1:0]  bs_eff;
  logic             in_acc;
  logic             load_ok, query_ok, add_ok;
  logic             div_start, div_done;
  logic [IDX_W-1:0] div_dividend, div_quo;
  logic [BS_W-1:0]  div_rem;
  logic             tag_step;
  logic [POS_W-1:0] walk_pos;
  brapq_req_t       req;
  logic             resp_valid;
  logic [VAL_W-1:0] resp_data;

  assign cnt_eff = (elem_count_r > CNT_MAX) ? CNT_MAX : elem_count_r;
  assign bs_eff  = (blk_size_r == '0) ? BS_W'(1) : blk_size_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign load_ok  = (in_left != '0) && (in_left <= cnt_eff);
  assign query_ok = (in_right != '0) && (in_right <= cnt_eff);
  assign add_ok   = (in_left != '0) && (in_right <= cnt_eff) && (in_left <= in_right);

  // only blocks strictly inside the range, and with a tag slot, take the tag
  assign tag_step = (blk_r > bl_r) && (blk_r < br_r) && (blk_r < BLK_LIMIT) && (off_r == '0);
  assign walk_pos = tag_step ? (pos_r + {{(POS_W-BS_W){1'b0}}, bs_eff}) : (pos_r + POS_W'(1));

  always_comb begin
    elem_count_nxt = elem_count_r;
    blk_size_nxt   = blk_size_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ELEMENT_COUNT: elem_count_nxt = cfg_data;
        REG_BLOCK_SIZE:    blk_size_nxt   = cfg_data[BS_W-1:0];
        default:           elem_count_nxt = elem_count_r;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    blk_nxt        = blk_r;
    bl_nxt         = bl_r;
    br_nxt         = br_r;
    off_nxt        = off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    div_start      = 1'b0;
    div_dividend   = IDX_W'(in_right - POS_W'(1));
    req            = '0;
    req.kind       = REQ_NONE;
    req.value      = value_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          left_nxt  = in_left;
          right_nxt = in_right;
          value_nxt = in_value;
          case (in_op)
            OP_LOAD: begin
              if (load_ok) state_nxt = S_LOAD;
            end
            OP_QUERY: begin
              if (query_ok) begin
                div_start = 1'b1;
                state_nxt = S_DIV_R;
              end
            end
            OP_ADD: begin
              if (add_ok) begin
                div_start    = 1'b1;
                div_dividend = IDX_W'(in_left - POS_W'(1));
                state_nxt    = S_DIV_L;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        req.kind      = REQ_LOAD;
        req.elem_addr = ELEM_AW'(left_r - POS_W'(1));
        state_nxt     = S_IDLE;
      end
      S_DIV_L: begin
        div_dividend = IDX_W'(right_r - POS_W'(1));
        if (div_done) begin
          bl_nxt    = div_quo;
          off_nxt   = div_rem;
          div_start = 1'b1;
          state_nxt = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          br_nxt    = div_quo;
          pos_nxt   = left_r;
          if (op_r == OP_ADD) begin
            blk_nxt   = bl_r;
            state_nxt = S_WALK;
          end else begin
            blk_nxt   = div_quo;
            state_nxt = S_QRY;
          end
        end
      end
      S_WALK: begin
        req.elem_addr = ELEM_AW'(pos_r - POS_W'(1));
        req.tag_addr  = blk_r[BLK_AW-1:0];
        req.use_tag   = 1'b1;
        pos_nxt       = walk_pos;
        if (tag_step) begin
          req.kind = REQ_TAG_ADD;
          blk_nxt  = blk_r + IDX_W'(1);
        end else begin
          req.kind = REQ_ELEM_ADD;
          if (off_r == bs_eff - BS_W'(1)) begin
            off_nxt = '0;
            blk_nxt = blk_r + IDX_W'(1);
          end else begin
            off_nxt = off_r + BS_W'(1);
          end
        end
        if (walk_pos > right_r) state_nxt = S_IDLE;
      end
      S_QRY: begin
        // hold the read until the output register is free
        if (!out_valid_r) begin
          req.kind      = REQ_QUERY;
          req.elem_addr = ELEM_AW'(right_r - POS_W'(1));
          req.tag_addr  = blk_r[BLK_AW-1:0];
          req.use_tag   = (blk_r < BLK_LIMIT);
          state_nxt     = S_QWAIT;
        end
      end
      S_QWAIT: begin
        if (resp_valid) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = resp_data;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      elem_count_r <= POS_W'(1024);
      blk_size_r   <= BS_W'(32);
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      elem_count_r <= elem_count_nxt;
      blk_size_r   <= blk_size_nxt;
    end
    op_r         <= op_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    blk_r        <= blk_nxt;
    bl_r         <= bl_nxt;
    br_r         <= br_nxt;
    off_r        <= off_nxt;
    out_result_r <= out_result_nxt;
  end

  brapq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bs_eff),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  brapq_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_data  (resp_data)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_resp_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    resp_valid |-> !out_valid_r)
    else $error("query response while output register is full");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (pos_r <= right_r) && (pos_r >= left_r))
    else $error("walk position left the add range");

  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_L) || (state_r == S_DIV_R))
    else $error("divider finished outside a divide state");

  a_tag_only_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (req.kind == REQ_TAG_ADD) |-> (blk_r > bl_r) && (blk_r < br_r))
    else $error("tag add on an edge block");

endmodule

@@ verif/tb_block_range_add_point_query.sv @@
// ----------------------------------------------------------------------------
// tb_block_range_add_point_query
// Self-checking bench for the blocked range-add / point-query store. Loads,
// range adds and point queries go in over the valid/stall input channel. A
// behavioral copy of the element array and block tags is kept alongside. Each
// query pushes its expected sum, and the result channel is checked in order.
// Both sides idle at random. The run steps through several block size and
// count settings, including zero, one and the field maximums.
// ----------------------------------------------------------------------------
module tb_block_range_add_point_query;
  timeunit 1ns;
  timeprecision 1ps;

  import brapq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = OP_ADD;
  logic [POS_W-1:0]         in_left = '0;
  logic [POS_W-1:0]         in_right = '0;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VAL_W-1:0]  out_result;
  logic                     cfg_we = 1'b0;
  logic [0:0]               cfg_index = REG_ELEMENT_COUNT;
  logic [POS_W-1:0]         cfg_data = '0;

  // shadow copy of the store
  logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] tag_mem  [MAX_BLOCKS];
  bit               loaded   [MAX_ELEMENTS];
  logic [POS_W-1:0] count_reg;
  logic [BS_W-1:0]  bsize_reg;

  logic [VAL_W-1:0] expected_sums[$];
  bit               item_took_effect;
  int unsigned      idle_pct = 25;
  int unsigned      error_count = 0;

  block_range_add_point_query u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_left    (in_left),
    .in_right   (in_right),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    error_count++;
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result", out_result, 'x);
      end else begin
        want = expected_sums.pop_front();
        if (out_result !== want) begin
          report_mismatch("result", out_result, want);
        end
      end
    end
  end

  function automatic int unsigned eff_count();
    return (32'(count_reg) > MAX_ELEMENTS) ? MAX_ELEMENTS : 32'(count_reg);
  endfunction

  function automatic int unsigned eff_block();
    return (bsize_reg == '0) ? 1 : 32'(bsize_reg);
  endfunction

  task automatic add_span(input int unsigned first, input int unsigned last,
                          input logic [VAL_W-1:0] amount);
    for (int unsigned p = first; p <= last; p++) begin
      elem_mem[ELEM_AW'(p - 1)] += amount;
    end
  endtask

  task automatic update_store(input logic [1:0] op, input logic [POS_W-1:0] lpos,
                              input logic [POS_W-1:0] rpos, input logic [VAL_W-1:0] val);
    int unsigned cnt, bs, a, b, bl, br;
    cnt = eff_count();
    bs = eff_block();
    a = 32'(lpos);
    b = 32'(rpos);
    item_took_effect = 1'b0;
    case (op)
      OP_LOAD: begin
        if (a >= 1 && a <= cnt) begin
          elem_mem[ELEM_AW'(a - 1)] = val;
          loaded[ELEM_AW'(a - 1)] = 1'b1;
          item_took_effect = 1'b1;
        end
      end
      OP_QUERY: begin
        if (b >= 1 && b <= cnt) begin
          bl = (b - 1) / bs;
          expected_sums.push_back(elem_mem[ELEM_AW'(b - 1)] +
                                  ((bl < MAX_BLOCKS) ? tag_mem[BLK_AW'(bl)] : '0));
          item_took_effect = 1'b1;
        end
      end
      OP_ADD: begin
        if (a >= 1 && b <= cnt && a <= b) begin
          bl = (a - 1) / bs;
          br = (b - 1) / bs;
          item_took_effect = 1'b1;
          if (bl == br) begin
            add_span(a, b, val);
          end else begin
            add_span(a, (bl + 1) * bs, val);
            for (int unsigned k = bl + 1; k < br; k++) begin
              // whole blocks past the tag array take the add per element
              if (k < MAX_BLOCKS) tag_mem[BLK_AW'(k)] += val;
              else add_span(k * bs + 1, (k + 1) * bs, val);
            end
            add_span(br * bs + 1, b, val);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] lpos,
                           input logic [POS_W-1:0] rpos, input logic [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_left  <= lpos;
    in_right <= rpos;
    in_value <= val;
    do begin
      @(posedge clk);
    end while (in_stall);
    update_store(op, lpos, rpos, val);
  endtask

  // no result pending, then time for the longest add walk to finish
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (64 + eff_count() + 2 * eff_block()) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ELEMENT_COUNT: count_reg = data;
      REG_BLOCK_SIZE:    bsize_reg = data[BS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [POS_W-1:0] cnt, input logic [POS_W-1:0] bs);
    wait_quiet();
    write_reg(REG_ELEMENT_COUNT, cnt);
    write_reg(REG_BLOCK_SIZE, bs);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned n_useful);
    int unsigned done, cnt, bs, roll, a, b;
    logic [1:0] op;
    logic [POS_W-1:0] lpos, rpos;
    logic [VAL_W-1:0] val;
    done = 0;
    while (done < n_useful) begin
      cnt = eff_count();
      bs = eff_block();
      val = {$urandom, $urandom};
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(3))
          0: val = 64'h8000_0000_0000_0000;
          1: val = 64'h7FFF_FFFF_FFFF_FFFF;
          2: val = '1;
          default: val = '0;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        op = 2'($urandom_range(3));
        lpos = POS_W'($urandom_range(2047));
        rpos = POS_W'($urandom_range(2047));
        // never read an element that was not loaded
        if (op == OP_QUERY && 32'(rpos) >= 1 && 32'(rpos) <= cnt &&
            !loaded[ELEM_AW'(rpos - POS_W'(1))]) begin
          op = OP_LOAD;
          lpos = rpos;
        end
      end else if (roll < 45) begin
        op = OP_ADD;
        a = $urandom_range(cnt, 1);
        if ($urandom_range(9) == 0) begin
          a = 1;
          b = cnt;
        end else if ($urandom_range(1)) begin
          b = a + $urandom_range(2 * bs);
          if (b > cnt) b = cnt;
        end else begin
          b = $urandom_range(cnt, a);
        end
        lpos = POS_W'(a);
        rpos = POS_W'(b);
      end else if (roll < 80) begin
        a = $urandom_range(cnt, 1);
        if (loaded[ELEM_AW'(a - 1)]) begin
          op = OP_QUERY;
          lpos = POS_W'($urandom_range(2047));
          rpos = POS_W'(a);
        end else begin
          op = OP_LOAD;
          lpos = POS_W'(a);
          rpos = POS_W'($urandom_range(2047));
        end
      end else begin
        op = OP_LOAD;
        lpos = POS_W'($urandom_range(cnt, 1));
        rpos = POS_W'($urandom_range(2047));
      end
      send_item(op, lpos, rpos, val);
      if (item_took_effect && roll >= 10) done++;
    end
  endtask

  task automatic test_directed();
    send_item(OP_LOAD, 1, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_LOAD, 1024, 0, 64'h8000_0000_0000_0000);
    send_item(OP_LOAD, 32, 0, '1);
    send_item(OP_LOAD, 33, 0, '0);
    send_item(OP_LOAD, 64, 0, 64'h0123_4567_89AB_CDEF);
    send_item(OP_LOAD, 65, 0, 64'd5);
    send_item(OP_QUERY, 0, 1, '0);
    send_item(OP_QUERY, 0, 1024, '0);
    send_item(OP_ADD, 1, 1024, 64'd1);
    send_item(OP_ADD, 30, 70, 64'h8000_0000_0000_0000);
    send_item(OP_ADD, 33, 33, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_ADD, 70, 40, 64'd9);         // reversed range
    send_item(OP_ADD, 0, 5, 64'd9);           // left below range
    send_item(OP_ADD, 5, 1025, 64'd9);        // right past count
    send_item(OP_QUERY, 0, 0, '0);
    send_item(OP_QUERY, 2047, 1025, '0);
    send_item(OP_QUERY, 0, 2047, '0);
    send_item(OP_LOAD, 0, 0, 64'd7);
    send_item(OP_LOAD, 2047, 2047, '1);
    send_item(OP_UNUSED, 1, 1, '1);
    send_item(OP_QUERY, 0, 32, '0);
    send_item(OP_QUERY, 0, 33, '0);
    send_item(OP_QUERY, 0, 64, '0);
    send_item(OP_QUERY, 0, 65, '0);
    send_item(OP_QUERY, 2047, 1, '0);
    send_item(OP_QUERY, 0, 1024, '0);
  endtask

  // one entry per block: most blocks sit past the tag array
  task automatic test_too_many_blocks();
    set_config(1024, 1);
    run_traffic(80);
  endtask

  task automatic test_zero_block_size();
    set_config(2047, 0);
    run_traffic(80);
  endtask

  task automatic test_empty_array();
    set_config(0, 32);
    send_item(OP_LOAD, 1, 1, 64'd3);
    send_item(OP_QUERY, 1, 1, '0);
    send_item(OP_ADD, 1, 1, 64'd3);
    send_item(OP_QUERY, 0, 1024, '0);
  endtask

  task automatic test_single_position();
    set_config(1, 63);
    run_traffic(40);
  endtask

  task automatic test_wide_blocks();
    set_config(1024, 63);
    run_traffic(150);
  endtask

  task automatic test_no_idle();
    set_config(1024, 32);
    idle_pct = 0;
    run_traffic(250);
    idle_pct = 25;
  endtask

  task automatic test_random_settings();
    logic [POS_W-1:0] cnt;
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(3) == 0) cnt = POS_W'($urandom_range(2047, 1025));
      else cnt = POS_W'($urandom_range(1024, 1));
      set_config(cnt, POS_W'($urandom_range(63)));
      run_traffic(85);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_BLOCKS; i++) tag_mem[BLK_AW'(i)] = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem_mem[ELEM_AW'(i)] = '0;
      loaded[ELEM_AW'(i)] = 1'b0;
    end
    count_reg = 11'd1024;
    bsize_reg = 6'd32;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_too_many_blocks();
    test_zero_block_size();
    test_empty_array();
    test_single_position();
    test_wide_blocks();
    test_no_idle();
    test_random_settings();
    wait_quiet();
    if (error_count == 0) begin
      $display("block_range_add_point_query: match");
    end else begin
      $display("block_range_add_point_query: mismatch");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("block_range_add_point_query: mismatch");
    $finish;
  end

endmodule
